@@ rtl/core/cdb_pkg.sv @@
// Shared types and constants for the circular deque buffer.
package cdb_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CapW  = 5;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  // request codes
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_SHIFT_UP   = 3'd1,
    CMD_SHIFT_DOWN = 3'd2,
    CMD_LOAD_BACK  = 3'd3,
    CMD_DROP_BACK  = 3'd4,
    CMD_CLEAR      = 3'd5
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [WordW-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/core/cdb_cell.sv @@
// One storage cell of the deque chain: a word, its valid bit and neighbor handoff.
module cdb_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cdb_pkg::cell_ctrl_t            ctrl_i,
  input  logic [cdb_pkg::WordW-1:0]      left_data_i,
  input  logic                           left_valid_i,
  input  logic [cdb_pkg::WordW-1:0]      right_data_i,
  input  logic                           right_valid_i,
  output logic [cdb_pkg::WordW-1:0]      data_o,
  output logic                           valid_o,
  output logic                           is_back_o
);
  import cdb_pkg::*;

  logic [WordW-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: begin
      end
      CMD_SHIFT_UP: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      CMD_SHIFT_DOWN: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      CMD_LOAD_BACK: begin
        // first empty cell after the occupied run takes the word
        if (!valid_q && left_valid_i) begin
          data_d  = ctrl_i.value;
          valid_d = 1'b1;
        end
      end
      CMD_DROP_BACK: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      CMD_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign valid_o   = valid_q;
  assign is_back_o = valid_q && !right_valid_i;

endmodule

@@ rtl/core/circular_deque_buffer_top.sv @@
// A result word is valid in the cycle after its request word is accepted.
// Throughput: one request per cycle while out_ready_i is high; a waiting result
//   holds off the next request until it is taken (single output register).
// The cycle rate is set by the cell row shift plus the back-cell select into the result register.
// Reset: all cells empty, capacity 16, output empty; stored words are not cleared.
module circular_deque_buffer_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        req_type_i,
  input  logic signed [cdb_pkg::WordW-1:0]  push_value_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cdb_pkg::WordW-1:0]  value_out_o,
  output logic [1:0]                        status_o,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import cdb_pkg::*;

  // Count of occupied cells needs to reach DEPTH itself.
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  // Compare width wide enough for both the count and the capacity register.
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [CapW-1:0] cap_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  // Clamp capacity into 1..DEPTH.
  logic [CmpW-1:0] cap_ext, depth_ext, eff_cap;
  assign cap_ext   = CmpW'(cap_q);
  assign depth_ext = CmpW'(DEPTH);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > depth_ext) begin
      eff_cap = depth_ext;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: cell 0 is the front, the back is the last valid cell.
  // ---------------------------------------------------------------------------
  logic [WordW-1:0] cell_data  [DEPTH];
  logic             cell_valid [DEPTH];
  logic             cell_back  [DEPTH];
  cell_ctrl_t       ctrl;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] left_data, right_data;
    logic             left_valid, right_valid;

    if (i == 0) begin : g_first
      // push at the front enters here
      assign left_data  = push_value_i;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    cdb_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .is_back_o     (cell_back[i])
    );
  end

  // Exactly one cell flags itself as the back when the deque is not empty;
  // AND-OR its word out.
  logic [WordW-1:0] back_word;
  always_comb begin
    back_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      back_word = back_word | (cell_data[i] & {WordW{cell_back[i]}});
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode and occupancy count
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             accept, empty, full;
  logic [WordW-1:0] res_word;
  logic [1:0]       res_status;

  assign accept = in_valid_i && in_ready_o;
  assign empty  = (cnt_q == '0);
  assign full   = (CmpW'(cnt_q) == eff_cap);

  always_comb begin
    ctrl.cmd   = CMD_HOLD;
    ctrl.value = push_value_i;
    cnt_d      = cnt_q;
    res_word   = '0;
    res_status = ST_OK;
    if (cfg_wr) begin
      // any capacity write empties the deque
      ctrl.cmd = CMD_CLEAR;
      cnt_d    = '0;
    end else if (accept) begin
      unique case (req_type_i)
        REQ_PUSH_BACK: begin
          if (full) begin
            res_status = ST_OVERFLOW;
          end else begin
            ctrl.cmd = CMD_LOAD_BACK;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        REQ_PUSH_FRONT: begin
          if (full) begin
            res_status = ST_OVERFLOW;
          end else begin
            ctrl.cmd = CMD_SHIFT_UP;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            ctrl.cmd = CMD_SHIFT_DOWN;
            cnt_d    = cnt_q - CntW'(1);
            res_word = cell_data[0];
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            ctrl.cmd = CMD_DROP_BACK;
            cnt_d    = cnt_q - CntW'(1);
            res_word = back_word;
          end
        end
        REQ_PEEK_FRONT: begin
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            res_word = cell_data[0];
          end
        end
        default: begin
          // undefined request: no state change, ok with zero word
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [WordW-1:0] out_word_q;
  logic [1:0]       out_status_q;

  assign in_ready_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the payload until the next accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q   <= res_word;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_word_q;
  assign status_o    = out_status_q;

endmodule

@@ rtl/core/cdb_checker.sv @@
// Port-level checks for the circular deque buffer, bound to its top level.
module cdb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [2:0]                        req_type_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cdb_pkg::WordW-1:0]  value_out_o,
  input logic [1:0]                        status_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [2:0]                        paddr,
  input logic                              pready
);
  import cdb_pkg::*;

  // an error result carries a zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> value_out_o == '0)
    else $error("error result with nonzero word");

  // a push never returns a word and never underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (req_type_i == REQ_PUSH_BACK || req_type_i == REQ_PUSH_FRONT)
    |=> out_valid_o && value_out_o == '0 && status_o != ST_UNDERFLOW)
    else $error("push result malformed");

  // a capacity write empties the deque: an immediate pop underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY
    ##1 in_valid_i && in_ready_o && req_type_i == REQ_POP_FRONT
    |=> status_o == ST_UNDERFLOW)
    else $error("deque not emptied by capacity write");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i
    |=> out_valid_o && $stable(value_out_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind circular_deque_buffer_top cdb_checker u_cdb_checker (.*);
